>>> design/rlt_pkg.sv
// Shared types, codes and helper functions of the link routing table.
package rlt_pkg;

  localparam int DEST_BITS_DEF = 12;
  localparam int NUM_LINKS_DEF = 6;
  localparam int LINK_W        = 3;
  localparam int DEST_W        = 12;
  localparam int MASK_W        = 7;
  localparam int STATUS_W      = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  // Byte address of the valid link mask register.
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_VALID_LINK_MASK = 3'd0;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_LINK    = 3'd1,
    ST_IN_EQ_OUT   = 3'd2,
    ST_CONFLICT    = 3'd3,
    ST_STRIP_LOCAL = 3'd4
  } status_t;

  typedef struct packed {
    logic              action;
    logic [LINK_W-1:0] in_link;
    logic [DEST_W-1:0] dest_id;
    logic [LINK_W-1:0] out_link;
  } in_item_t;

  typedef struct packed {
    logic [LINK_W-1:0]   next_link;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // A classified beat as it waits between the front and the back.
  typedef struct packed {
    in_item_t item;
    logic     il_ok;
    logic     ol_ok;
    logic     in_table;
  } rlt_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RESOLVE
  } bk_state_t;

  // Link 0 always exists; a ring link exists when it is in range and enabled.
  function automatic logic link_ok(logic [LINK_W-1:0] n, logic [MASK_W-1:0] mask,
                                   int num_links);
    logic ok;
    if (n == '0) begin
      ok = 1'b1;
    end else if (int'(n) > num_links) begin
      ok = 1'b0;
    end else begin
      ok = mask[n];
    end
    return ok;
  endfunction

endpackage

>>> design/rlt_front.sv
// Front end: accepts command beats and classifies their links.
module rlt_front #(
  parameter int NUM_LINKS = rlt_pkg::NUM_LINKS_DEF
) (
  input  logic                         start,
  input  rlt_pkg::in_item_t            in_item,
  input  logic [rlt_pkg::MASK_W-1:0]   valid_link_mask,
  input  logic                         clearing,
  input  rlt_pkg::q_status_t           q_stat,
  output logic                         busy,
  output logic                         push,
  output rlt_pkg::rlt_entry_t          entry
);

  assign busy = clearing | q_stat.full;
  assign push = start & ~busy;

  always_comb begin
    entry.item     = in_item;
    entry.il_ok    = rlt_pkg::link_ok(in_item.in_link, valid_link_mask, NUM_LINKS);
    entry.ol_ok    = rlt_pkg::link_ok(in_item.out_link, valid_link_mask, NUM_LINKS);
    entry.in_table = (int'(in_item.in_link) <= NUM_LINKS);
  end

endmodule

>>> design/rlt_queue.sv
// Short queue of classified beats between the front and the back.
module rlt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rlt_pkg::rlt_entry_t push_entry,
  input  logic                pop,
  output rlt_pkg::rlt_entry_t head,
  output rlt_pkg::q_status_t  q_stat
);

  localparam int PTR_W = (rlt_pkg::QUEUE_DEPTH > 1) ? $clog2(rlt_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rlt_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rlt_pkg::QUEUE_DEPTH - 1);

  rlt_pkg::rlt_entry_t slots_r [rlt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head         = slots_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(rlt_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("beat pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("beat popped from an empty queue");

endmodule

>>> design/rlt_back.sv
// Back end: holds the route and strip memory, resolves lookups and inserts.
module rlt_back #(
  parameter int DEST_BITS = rlt_pkg::DEST_BITS_DEF,
  parameter int NUM_LINKS = rlt_pkg::NUM_LINKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rlt_pkg::MASK_W-1:0] valid_link_mask,
  input  rlt_pkg::rlt_entry_t        q_head,
  input  rlt_pkg::q_status_t         q_stat,
  output logic                       q_pop,
  output logic                       clearing,
  output logic                       out_valid,
  output rlt_pkg::out_item_t         out_item
);

  localparam int LINK_AW = $clog2(NUM_LINKS + 1);
  localparam int ADDR_W  = LINK_AW + DEST_BITS;
  localparam int DEPTH   = (NUM_LINKS + 1) << DEST_BITS;
  localparam int WIDE_W  = ((DEST_BITS > rlt_pkg::DEST_W) ? DEST_BITS : rlt_pkg::DEST_W) + 1;
  localparam int WORD_W  = rlt_pkg::LINK_W + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Each word holds the strip bit above the 3-bit output link.
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  rlt_pkg::bk_state_t  state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  rlt_pkg::rlt_entry_t cur_r, cur_nxt;
  logic                out_valid_r, out_valid_nxt;
  rlt_pkg::out_item_t  out_item_r, out_item_nxt;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [ADDR_W-1:0]   cur_addr;

  rlt_pkg::out_item_t  res_item;
  logic                res_write;
  logic [WORD_W-1:0]   res_wdata;
  logic                strip;
  logic [rlt_pkg::LINK_W-1:0] stored;
  logic [rlt_pkg::LINK_W-1:0] cur_link;

  function automatic logic [ADDR_W-1:0] entry_addr(rlt_pkg::rlt_entry_t e);
    logic [WIDE_W-1:0] dest_wide;
    dest_wide = {{(WIDE_W - rlt_pkg::DEST_W){1'b0}}, e.item.dest_id};
    return {e.item.in_link[LINK_AW-1:0], dest_wide[DEST_BITS-1:0]};
  endfunction

  assign mem_raddr = q_head.in_table ? entry_addr(q_head) : '0;
  assign cur_addr  = entry_addr(cur_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign strip    = rd_data_r[WORD_W-1];
  assign stored   = rd_data_r[rlt_pkg::LINK_W-1:0];
  assign cur_link = cur_r.in_table ? stored : '0;

  always_comb begin
    res_item.next_link = '0;
    res_item.status    = rlt_pkg::ST_OK;
    res_write          = 1'b0;
    res_wdata          = '0;
    if (cur_r.item.action == rlt_pkg::ACT_LOOKUP) begin
      if (!cur_r.il_ok) begin
        res_item.status = rlt_pkg::ST_BAD_LINK;
      end else if (cur_r.item.in_link != '0 && !strip) begin
        // Not yet stripped: the packet stays on the ring it came in on.
        res_item.next_link = cur_r.item.in_link;
      end else begin
        res_item.next_link = stored;
        if (!rlt_pkg::link_ok(stored, valid_link_mask, NUM_LINKS)) begin
          res_item.status = rlt_pkg::ST_BAD_LINK;
        end
      end
    end else begin
      res_item.next_link = cur_link;
      priority if (!cur_r.il_ok || !cur_r.ol_ok) begin
        res_item.status = rlt_pkg::ST_BAD_LINK;
      end else if (cur_r.item.in_link == cur_r.item.out_link) begin
        res_item.status = rlt_pkg::ST_IN_EQ_OUT;
      end else if (cur_r.item.in_link == '0 && strip) begin
        res_item.status = rlt_pkg::ST_STRIP_LOCAL;
      end else if (cur_link != '0 &&
                   !rlt_pkg::link_ok(cur_link, valid_link_mask, NUM_LINKS)) begin
        res_item.status = rlt_pkg::ST_BAD_LINK;
      end else if (cur_link != '0 && cur_link != cur_r.item.out_link) begin
        res_item.status = rlt_pkg::ST_CONFLICT;
      end else begin
        res_write = 1'b1;
        res_wdata = {(cur_r.item.in_link != '0) | strip, cur_link | cur_r.item.out_link};
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cur_nxt       = cur_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_addr_r;
    mem_wdata     = '0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      rlt_pkg::BK_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = rlt_pkg::BK_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      rlt_pkg::BK_IDLE: begin
        // The memory read of the head beat is issued in the same cycle.
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head;
          state_nxt = rlt_pkg::BK_RESOLVE;
        end
      end
      rlt_pkg::BK_RESOLVE: begin
        mem_we        = res_write;
        mem_waddr     = cur_addr;
        mem_wdata     = res_wdata;
        out_valid_nxt = 1'b1;
        out_item_nxt  = res_item;
        state_nxt     = rlt_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = rlt_pkg::BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlt_pkg::BK_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_item_r <= out_item_nxt;
  end

  assign clearing  = (state_r == rlt_pkg::BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_result_after_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == rlt_pkg::BK_RESOLVE))
    else $error("result strobe without a preceding resolve cycle");

  a_pop_leads_to_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == rlt_pkg::BK_RESOLVE)
    else $error("popped beat was not resolved in the next cycle");

  a_write_only_when_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rlt_pkg::BK_RESOLVE && state_r != rlt_pkg::BK_CLEAR) |-> !mem_we)
    else $error("table written outside a resolve or clearing cycle");

endmodule

>>> design/link_routing_table_lookup_insert.sv
// Top level of the link routing table with lookup and insert commands.
//
// A command beat (in_item: action, in_link, dest_id, out_link) is taken at a
// rising edge where start is high and busy is low. Every beat gives exactly
// one result beat (out_item: next_link, status), shown for one cycle with
// out_valid high; the receiver cannot stall, so nothing waits on it.
// A lookup chooses the next link; an insert records a route and reports the
// entry it found, writing nothing when a check fails.
// A beat waits in the queue behind any beats ahead of it. The back end
// pops it in BK_IDLE and reads its table word, then checks it and writes the
// word back in BK_RESOLVE, where the result is registered; it takes a new
// beat only when it is through with the last, and a two-entry queue lets the
// front take beats while the back is working.
// The valid link mask is written through the APB-style port at address 0
// and reads back on prdata; the user must write it only while the block is
// idle, as the block itself does not enforce this.
// After reset the mask is zero and the back end clears the whole table of
// (NUM_LINKS+1) << DEST_BITS words (28672 with the default parameters), one
// word a cycle; busy stays high until the sweep is done.
module link_routing_table_lookup_insert #(
  parameter int DEST_BITS = rlt_pkg::DEST_BITS_DEF,
  parameter int NUM_LINKS = rlt_pkg::NUM_LINKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  rlt_pkg::in_item_t               in_item,
  output logic                            out_valid,
  output rlt_pkg::out_item_t              out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rlt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rlt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rlt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [rlt_pkg::MASK_W-1:0] mask_r;
  logic                       cfg_hit;
  logic                       push;
  logic                       pop;
  logic                       clearing;
  rlt_pkg::rlt_entry_t        entry;
  rlt_pkg::rlt_entry_t        q_head;
  rlt_pkg::q_status_t         q_stat;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[rlt_pkg::CFG_ADDR_W-1:2] ==
                    rlt_pkg::CFG_ADDR_VALID_LINK_MASK[rlt_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      mask_r <= pwdata[rlt_pkg::MASK_W-1:0];
    end
  end

  assign prdata = cfg_hit ? {{(rlt_pkg::CFG_DATA_W - rlt_pkg::MASK_W){1'b0}}, mask_r} : '0;

  rlt_front #(
    .NUM_LINKS(NUM_LINKS)
  ) u_front (
    .start          (start),
    .in_item        (in_item),
    .valid_link_mask(mask_r),
    .clearing       (clearing),
    .q_stat         (q_stat),
    .busy           (busy),
    .push           (push),
    .entry          (entry)
  );

  rlt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(entry),
    .pop       (pop),
    .head      (q_head),
    .q_stat    (q_stat)
  );

  rlt_back #(
    .DEST_BITS(DEST_BITS),
    .NUM_LINKS(NUM_LINKS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid_link_mask(mask_r),
    .q_head         (q_head),
    .q_stat         (q_stat),
    .q_pop          (pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_item       (out_item)
  );

endmodule
